// ===== src/sbbc_pkg.sv =====
package sbbc_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  // field widths
  localparam int DATA_W     = 8;
  localparam int CNT_W      = 32;
  localparam int IDLE_W     = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 152;

  // configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STROBE_POL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_IDLE_TIMEOUT  = 3'd4;
  localparam logic [IDLE_W-1:0]     IDLE_TIMEOUT_RESET = 16'd100;

  // one sampled item
  typedef struct packed {
    logic              clear_stats;
    logic              pop_request;
    logic              ms_tick;
    logic [DATA_W-1:0] data_in;
    logic              strobe_level;
  } item_t;

  // fifo status for the current item
  typedef struct packed {
    logic              pop_ok;
    logic              push_ok;
    logic [FILL_W-1:0] fill;
  } fifo_stat_t;

  // per-item status, everything except the popped byte
  typedef struct packed {
    logic              pop_valid;
    logic              burst_active;
    logic              burst_ended;
    logic [CNT_W-1:0]  burst_bytes;
    logic [CNT_W-1:0]  burst_total;
    logic [CNT_W-1:0]  bytes_total;
    logic [CNT_W-1:0]  overflow_total;
    logic [FILL_W-1:0] fifo_fill;
  } stat_t;

endpackage

// ===== src/sbbc_fifo.sv =====
module sbbc_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          pop_req,
  input  logic                          push_req,
  input  logic [sbbc_pkg::DATA_W-1:0]   wdata,
  output sbbc_pkg::fifo_stat_t          stat,
  output logic [sbbc_pkg::DATA_W-1:0]   rd_data
);

  logic [sbbc_pkg::DATA_W-1:0] mem [sbbc_pkg::FIFO_DEPTH];
  logic [sbbc_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [sbbc_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [sbbc_pkg::FILL_W-1:0] fill_r, fill_mid;
  logic [sbbc_pkg::DATA_W-1:0] rd_data_r;
  logic                        pop_ok, push_ok;

  // pop is served before the push of the same item
  always_comb begin
    pop_ok   = pop_req && (fill_r != '0);
    fill_mid = fill_r - sbbc_pkg::FILL_W'(pop_ok);
    push_ok  = push_req && (fill_mid != sbbc_pkg::FILL_W'(sbbc_pkg::FIFO_DEPTH));
    head_nxt = (head_r == sbbc_pkg::PTR_W'(sbbc_pkg::FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    tail_nxt = (tail_r == sbbc_pkg::PTR_W'(sbbc_pkg::FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  end

  assign stat.pop_ok  = pop_ok;
  assign stat.push_ok = push_ok;
  assign stat.fill    = fill_mid + sbbc_pkg::FILL_W'(push_ok);
  assign rd_data      = rd_data_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (accept) begin
      if (pop_ok) head_r <= head_nxt;
      if (push_ok) tail_r <= tail_nxt;
      fill_r <= stat.fill;
    end
  end

  // byte store, read returns the old contents on a same-entry write
  always_ff @(posedge clk) begin
    if (accept && push_ok) mem[tail_r] <= wdata;
    if (accept && pop_ok) rd_data_r <= mem[head_r];
  end

endmodule

// ===== src/sbbc_ctrl.sv =====
module sbbc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  sbbc_pkg::item_t               item,
  input  logic                          strobe_active_high,
  input  logic [sbbc_pkg::IDLE_W-1:0]   idle_timeout,
  input  sbbc_pkg::fifo_stat_t          fstat,
  output logic                          edge_det,
  output sbbc_pkg::stat_t               stat
);

  logic                        strobe_prev_r;
  logic                        open_r, open_nxt, open_b;
  logic [sbbc_pkg::IDLE_W-1:0] idle_r, idle_nxt, idle_inc;
  logic [sbbc_pkg::CNT_W-1:0]  len_r, len_nxt;
  logic [sbbc_pkg::CNT_W-1:0]  bursts_r, bursts_nxt;
  logic [sbbc_pkg::CNT_W-1:0]  bytes_r, bytes_nxt;
  logic [sbbc_pkg::CNT_W-1:0]  drops_r, drops_nxt;
  logic                        ended;

  // active strobe edge against the previous sample
  assign edge_det = strobe_active_high ? (!strobe_prev_r && item.strobe_level)
                                       : (strobe_prev_r && !item.strobe_level);
  assign idle_inc = idle_r + 1'b1;

  // clear first, then edge and push, else idle timeout
  always_comb begin
    open_b     = item.clear_stats ? 1'b0 : open_r;
    open_nxt   = open_b;
    idle_nxt   = item.clear_stats ? '0 : idle_r;
    len_nxt    = item.clear_stats ? '0 : len_r;
    bursts_nxt = item.clear_stats ? '0 : bursts_r;
    bytes_nxt  = item.clear_stats ? '0 : bytes_r;
    drops_nxt  = item.clear_stats ? '0 : drops_r;
    ended      = 1'b0;
    if (edge_det) begin
      if (!open_b) begin
        open_nxt   = 1'b1;
        len_nxt    = '0;
        bursts_nxt = bursts_nxt + 1'b1;
      end
      idle_nxt = '0;
      if (fstat.push_ok) begin
        bytes_nxt = bytes_nxt + 1'b1;
        len_nxt   = len_nxt + 1'b1;
      end else begin
        drops_nxt = drops_nxt + 1'b1;
      end
    end else if (open_b && item.ms_tick) begin
      idle_nxt = idle_inc;
      // a zero timeout acts as one, and a wrapped count closes too
      if (idle_inc >= idle_timeout || idle_inc == '0) begin
        open_nxt = 1'b0;
        idle_nxt = '0;
        ended    = 1'b1;
      end
    end
  end

  assign stat.pop_valid      = fstat.pop_ok;
  assign stat.burst_active   = open_nxt;
  assign stat.burst_ended    = ended;
  assign stat.burst_bytes    = len_nxt;
  assign stat.burst_total    = bursts_nxt;
  assign stat.bytes_total    = bytes_nxt;
  assign stat.overflow_total = drops_nxt;
  assign stat.fifo_fill      = fstat.fill;

  // burst state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_prev_r <= 1'b0;
      open_r        <= 1'b0;
      idle_r        <= '0;
      len_r         <= '0;
      bursts_r      <= '0;
      bytes_r       <= '0;
      drops_r       <= '0;
    end else if (accept) begin
      strobe_prev_r <= item.strobe_level;
      open_r        <= open_nxt;
      idle_r        <= idle_nxt;
      len_r         <= len_nxt;
      bursts_r      <= bursts_nxt;
      bytes_r       <= bytes_nxt;
      drops_r       <= drops_nxt;
    end
  end

endmodule

// ===== src/strobed_byte_burst_capture.sv =====
// channel | direction | transfer
// in_     | slave     | one sampled item: strobe, data byte, ms tick, pop, clear
// out_    | master    | one status item per input item, pop_valid in tuser
// cfg_    | apb slave | strobe polarity (0x0), idle timeout in ticks (0x4)
//
// one item per cycle unless output stalls; results pass the status stage and output reg
// the status stage lines up with the fifo read port: the popped byte comes from a registered read
// a stalled output holds one result and one more in the pipeline stage, then ready drops
// reset clears burst state, counters and fifo pointers; stored bytes are not cleared
module strobed_byte_burst_capture (
  input  logic                                clk,
  input  logic                                rst_n,
  // [0] strobe_level, [8:1] data_in, [9] ms_tick, [10] pop_request, [11] clear_stats
  input  logic [sbbc_pkg::IN_W-1:0]           in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] pop_data, [8] burst_active, [9] burst_ended, [41:10] burst_bytes,
  // [73:42] burst_total, [105:74] bytes_total, [137:106] overflow_total,
  // [148:138] fifo_fill
  output logic [sbbc_pkg::OUT_W-1:0]          out_tdata,
  // [0] pop_valid
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sbbc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  sbbc_pkg::item_t             item;
  sbbc_pkg::fifo_stat_t        fstat;
  sbbc_pkg::stat_t             stat, s1_stat_r, out_stat_r;
  logic [sbbc_pkg::DATA_W-1:0] rd_data, out_byte_r;
  logic                        in_acc, edge_det;
  logic                        s1_v_r, out_v_r, out_load;
  logic                        pol_r;
  logic [sbbc_pkg::IDLE_W-1:0] timeout_r;
  logic                        cfg_wr;

  assign item = sbbc_pkg::item_t'(in_tdata[11:0]);

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r     <= 1'b1;
      timeout_r <= sbbc_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr == sbbc_pkg::ADDR_STROBE_POL) pol_r <= cfg_pwdata[0];
      if (cfg_paddr == sbbc_pkg::ADDR_IDLE_TIMEOUT) timeout_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == sbbc_pkg::ADDR_STROBE_POL) cfg_prdata = {31'd0, pol_r};
    else if (cfg_paddr == sbbc_pkg::ADDR_IDLE_TIMEOUT) cfg_prdata = {16'd0, timeout_r};
  end

  // pipeline handshake
  assign out_load  = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  sbbc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .pop_req  (item.pop_request),
    .push_req (edge_det),
    .wdata    (item.data_in),
    .stat     (fstat),
    .rd_data  (rd_data)
  );

  sbbc_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (in_acc),
    .item               (item),
    .strobe_active_high (pol_r),
    .idle_timeout       (timeout_r),
    .fstat              (fstat),
    .edge_det           (edge_det),
    .stat               (stat)
  );

  // valid flags of the status stage and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) s1_v_r <= 1'b1;
      else if (out_load) s1_v_r <= 1'b0;
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // payload: status is held in the status stage to line up with the registered memory read
  always_ff @(posedge clk) begin
    if (in_acc) s1_stat_r <= stat;
    if (out_load) begin
      out_stat_r <= s1_stat_r;
      out_byte_r <= s1_stat_r.pop_valid ? rd_data : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_stat_r.pop_valid;
  assign out_tdata  = {3'd0, out_stat_r.fifo_fill, out_stat_r.overflow_total,
                       out_stat_r.bytes_total, out_stat_r.burst_total,
                       out_stat_r.burst_bytes, out_stat_r.burst_ended,
                       out_stat_r.burst_active, out_byte_r};

endmodule

// ===== src/sbbc_checker.sv =====
module sbbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic [sbbc_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready
);

  // popped byte reads zero when no pop happened
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("pop_data nonzero without pop_valid");

  // an ended burst is no longer active
  a_end_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8])
    else $error("burst_ended with burst_active");

  // fill level never exceeds the fifo depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[148:138] <= 11'(sbbc_pkg::FIFO_DEPTH))
    else $error("fifo_fill above depth");

  // an ending burst had a nonzero burst count
  a_end_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[73:42] != 32'd0)
    else $error("burst ended with zero burst_total");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed under stall");

endmodule

bind strobed_byte_burst_capture sbbc_checker u_sbbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
